### rtl/fbq_pkg.sv
// Frame buffer queue package: operation and status codes, item types, defaults.
// No dependencies; imported by every module of the frame buffer queue.
package fbq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 8;
  localparam int FRAME_ID_W   = 8;
  localparam int OCC_W        = 5;

  // operation codes carried in the mode field
  typedef enum logic [3:0] {
    MODE_PUT_TAIL     = 4'd0,
    MODE_PUT_HEAD     = 4'd1,
    MODE_GET_HEAD     = 4'd2,
    MODE_GET_UNLOCKED = 4'd3,
    MODE_GET_ID       = 4'd4,
    MODE_PEEK         = 4'd5,
    MODE_COUNT        = 4'd6,
    MODE_FLUSH        = 4'd7,
    MODE_SET_LOCK     = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]            mode;
    logic [FRAME_ID_W-1:0] frame_id;
    logic                  lock_flag;
  } fbq_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FRAME_ID_W-1:0] out_frame_id;
    logic                  out_locked;
    logic [OCC_W-1:0]      occupancy;
  } fbq_out_t;

endpackage

### rtl/fbq_store.sv
// Slot store: ids and locked flags, one write port and one registered read port.
// Depends on fbq_pkg.
module fbq_store
  import fbq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ID_WIDTH-1:0]      wr_id,
  input  logic                     wr_lk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ID_WIDTH-1:0]      rd_id,
  output logic                     rd_lk
);

  logic [ID_WIDTH-1:0] ids [DEPTH];
  logic                lks [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ids[wr_addr] <= wr_id;
      lks[wr_addr] <= wr_lk;
    end
    rd_id <= ids[rd_addr];
    rd_lk <= lks[rd_addr];
  end

endmodule

### rtl/fbq_seq.sv
// Queue sequencer: walks the slot store one entry per cycle with a shared
// comparator, shifts entries to open or close gaps. Depends on fbq_pkg, fbq_store.
module fbq_seq
  import fbq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  fbq_in_t  start_item,
  output logic     idle,
  output logic     res_valid,
  input  logic     res_take,
  output fbq_out_t res_item
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHDN, S_SHUP, S_HEADWR, S_DONE
  } state_t;

  state_t              state;
  logic [3:0]          op;
  logic [ID_WIDTH-1:0] key_id;
  logic                key_lk;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    rd_pos;
  logic                rd_vld;
  logic                primed;
  status_t             res_status;
  logic [ID_WIDTH-1:0] res_id;
  logic                res_lk;

  logic [AW-1:0]       rd_addr;
  logic [ID_WIDTH-1:0] rd_id;
  logic                rd_lk;
  logic                we;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_id;
  logic                wr_lk;
  logic                hit;
  logic                full;
  logic [CNT_W-1:0]    pos_dn;
  logic [CNT_W-1:0]    pos_up;
  logic [ID_WIDTH+FRAME_ID_W-1:0] id_in_wide;
  logic [ID_WIDTH+FRAME_ID_W-1:0] id_out_wide;
  logic [CNT_W+OCC_W-1:0]         occ_wide;

  fbq_store #(.DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH)) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .wr_lk   (wr_lk),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_lk   (rd_lk)
  );

  assign full    = (cnt >= CNT_W'(DEPTH));
  assign pos_dn  = rd_pos - 1'b1;
  assign pos_up  = rd_pos + 1'b1;
  assign rd_addr = (idx < CNT_W'(DEPTH)) ? idx[AW-1:0] : '0;

  // shared comparator
  always_comb begin
    priority case (op)
      MODE_GET_UNLOCKED:       hit = !rd_lk;
      MODE_GET_HEAD, MODE_PEEK: hit = 1'b1;
      default:                 hit = (rd_id == key_id);
    endcase
  end

  // store write port
  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wr_id   = key_id;
    wr_lk   = key_lk;
    unique case (state)
      S_SCAN: begin
        if (primed && !rd_vld && op == MODE_PUT_TAIL && !full) begin
          we      = 1'b1;
          wr_addr = cnt[AW-1:0];
        end else if (primed && rd_vld && hit && op == MODE_SET_LOCK) begin
          we      = 1'b1;
          wr_addr = rd_pos[AW-1:0];
          wr_id   = rd_id;
        end
      end
      S_SHDN: begin
        if (rd_vld) begin
          we      = 1'b1;
          wr_addr = pos_dn[AW-1:0];
          wr_id   = rd_id;
          wr_lk   = rd_lk;
        end
      end
      S_SHUP: begin
        if (primed) begin
          we      = 1'b1;
          wr_addr = pos_up[AW-1:0];
          wr_id   = rd_id;
          wr_lk   = rd_lk;
        end
      end
      S_HEADWR: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  assign id_in_wide = {{ID_WIDTH{1'b0}}, start_item.frame_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      primed <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op         <= start_item.mode;
            key_id     <= id_in_wide[ID_WIDTH-1:0];
            key_lk     <= start_item.lock_flag;
            idx        <= '0;
            primed     <= 1'b0;
            res_status <= ST_OK;
            res_id     <= '0;
            res_lk     <= 1'b0;
            unique case (start_item.mode)
              MODE_PUT_TAIL, MODE_GET_HEAD, MODE_GET_UNLOCKED,
              MODE_GET_ID, MODE_PEEK, MODE_SET_LOCK: begin
                state <= S_SCAN;
              end
              MODE_PUT_HEAD: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (cnt == '0) begin
                  state <= S_HEADWR;
                end else begin
                  idx   <= cnt - 1'b1;
                  state <= S_SHUP;
                end
              end
              MODE_FLUSH: begin
                cnt   <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          primed <= 1'b1;
          idx    <= idx + 1'b1;
          rd_pos <= idx;
          rd_vld <= (idx < cnt);
          if (primed) begin
            if (!rd_vld) begin
              if (op == MODE_PUT_TAIL) begin
                if (full) res_status <= ST_FULL;
                else      cnt        <= cnt + 1'b1;
              end else begin
                res_status <= ST_EMPTY;
              end
              state <= S_DONE;
            end else if (hit) begin
              priority case (op)
                MODE_PUT_TAIL: begin
                  res_status <= ST_DUP;
                  state      <= S_DONE;
                end
                MODE_PEEK: begin
                  res_id <= rd_id;
                  res_lk <= rd_lk;
                  state  <= S_DONE;
                end
                MODE_SET_LOCK: begin
                  res_id <= key_id;
                  res_lk <= key_lk;
                  state  <= S_DONE;
                end
                default: begin
                  res_id <= rd_id;
                  res_lk <= rd_lk;
                  state  <= S_SHDN;
                end
              endcase
            end
          end
        end
        S_SHDN: begin
          idx    <= idx + 1'b1;
          rd_pos <= idx;
          rd_vld <= (idx < cnt);
          if (!rd_vld) begin
            cnt   <= cnt - 1'b1;
            state <= S_DONE;
          end
        end
        S_SHUP: begin
          primed <= 1'b1;
          idx    <= idx - 1'b1;
          rd_pos <= idx;
          if (primed && rd_pos == '0) state <= S_HEADWR;
        end
        S_HEADWR: begin
          cnt   <= cnt + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle        = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign id_out_wide = {{FRAME_ID_W{1'b0}}, res_id};
  assign occ_wide    = {{OCC_W{1'b0}}, cnt};

  always_comb begin
    res_item.status       = res_status;
    res_item.out_frame_id = id_out_wide[FRAME_ID_W-1:0];
    res_item.out_locked   = res_lk;
    res_item.occupancy    = occ_wide[OCC_W-1:0];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("item started while busy");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHDN && !rd_vld) |=> cnt == $past(cnt) - 1'b1)
    else $error("removal did not drop count by one");

  a_dup_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_DUP) |-> op == MODE_PUT_TAIL)
    else $error("duplicate status on an operation other than put tail");

  a_shdn_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHDN && rd_vld) |-> rd_pos != '0)
    else $error("gap close would write below the head");

endmodule

### rtl/frame_buffer_queue.sv
// Frame buffer queue top level: input item capture, sequencer, result register.
// Depends on fbq_pkg, fbq_seq (which holds fbq_store).
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_stall  | in_item  : mode, frame_id, lock_flag
//   result   | out_valid / out_stall| out_item : status, out_frame_id, out_locked,
//            |                      |            occupancy
//
// One item at a time. A scan reads one slot per cycle through the store's
// registered read port, so a lookup busies the sequencer until it hits or reads
// past the last entry. A removal keeps stepping past the hit to close the gap
// and a put at head shifts every entry up. Count, flush and unknown modes
// finish without a scan.
// in_stall is high whenever the sequencer is busy.
// The result register lets the next item start while a result waits on
// out_stall; a finished item holds in the sequencer until the register frees.
// rst (synchronous) empties the queue; slot contents are not cleared.
module frame_buffer_queue
  import fbq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  fbq_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output fbq_out_t out_item
);

  logic     seq_idle;
  logic     start;
  logic     res_valid;
  logic     res_take;
  fbq_out_t res_item;

  // accept only while the sequencer is idle
  assign in_stall = !seq_idle;
  assign start    = in_valid && !in_stall;

  fbq_seq #(.DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_item (in_item),
    .idle       (seq_idle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_item   (res_item)
  );

  // result register: load when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res_item;
    end
  end

endmodule
